// ----- rtl/fsbf_pkg.sv -----
// Shared types and constants for the frame store with 3x3 box filter.
// Used by fsbf_ctrl, fsbf_dpath and frame_store_box_filter_3x3.
package fsbf_pkg;

   // Fixed field widths
   localparam int CHANNEL_BITS   = 24;
   localparam int COORD_BITS     = 9;
   localparam int CFG_SIZE_BITS  = 10;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = CFG_SIZE_BITS;

   // Defaults for the frame store size
   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   // Sum of nine channels, biased so it is never negative
   localparam int SUM_BITS   = CHANNEL_BITS + 4;
   localparam int DIV_SHIFT  = SUM_BITS + 4;
   localparam int RECIP_BITS = SUM_BITS + 1;
   localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_NINE =
      RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9);
   localparam logic [SUM_BITS-1:0] ACC_BIAS = SUM_BITS'(9) << (CHANNEL_BITS - 1);

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SUPERSAMPLE  = 2'd2;

   // Commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Neighbor selects
   localparam logic [1:0] TAP_PREV   = 2'd0;
   localparam logic [1:0] TAP_CENTER = 2'd1;
   localparam logic [1:0] TAP_NEXT   = 2'd2;

   typedef logic signed [CHANNEL_BITS-1:0] chan_type;

   typedef struct packed {
      logic                  command;
      logic [COORD_BITS-1:0] column;
      logic [COORD_BITS-1:0] row_index;
      chan_type              red_in;
      chan_type              green_in;
      chan_type              blue_in;
   } req_type;

   typedef struct packed {
      chan_type red_out;
      chan_type green_out;
      chan_type blue_out;
   } rsp_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

   typedef enum logic [1:0] {
      OUT_ZERO,
      OUT_RAW,
      OUT_MEAN
   } out_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        capture;
      logic        mem_wr;
      logic        mem_rd;
      logic [1:0]  col_sel;
      logic [1:0]  row_sel;
      logic        acc_clear;
      logic        acc_en;
      logic        mult_en;
      logic        out_load;
      out_sel_type out_sel;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_read;
      logic in_frame;
      logic supersample;
      logic out_free;
   } ctrl_sts_type;

endpackage

// ----- rtl/fsbf_ctrl.sv -----
// Sequencer for the frame store: decodes each beat and steps the datapath
// through writes, plain reads and nine-tap filtered reads. Uses fsbf_pkg.
module fsbf_ctrl
   import fsbf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FILTER,
      ST_DRAIN,
      ST_SCALE,
      ST_DONE
   } state_type;

   state_type   state_ff,   state_in;
   logic [1:0]  col_cnt_ff, col_cnt_in;
   logic [1:0]  row_cnt_ff, row_cnt_in;
   out_sel_type out_sel_ff, out_sel_in;

   logic first_tap;
   logic last_tap;

   assign first_tap = (col_cnt_ff == TAP_PREV) && (row_cnt_ff == TAP_PREV);
   assign last_tap  = (col_cnt_ff == TAP_NEXT) && (row_cnt_ff == TAP_NEXT);
   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      col_cnt_in    = col_cnt_ff;
      row_cnt_in    = row_cnt_ff;
      out_sel_in    = out_sel_ff;
      cmd           = '0;
      cmd.col_sel   = TAP_CENTER;
      cmd.row_sel   = TAP_CENTER;
      cmd.out_sel   = out_sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!sts.is_read) begin
               cmd.mem_wr = sts.in_frame;
               state_in   = ST_IDLE;
            end else if (!sts.in_frame) begin
               out_sel_in = OUT_ZERO;
               state_in   = ST_DONE;
            end else if (!sts.supersample) begin
               cmd.mem_rd = 1'b1;
               out_sel_in = OUT_RAW;
               state_in   = ST_DONE;
            end else begin
               cmd.acc_clear = 1'b1;
               col_cnt_in    = TAP_PREV;
               row_cnt_in    = TAP_PREV;
               state_in      = ST_FILTER;
            end
         end
         ST_FILTER: begin
            // one neighbor read per cycle, its data accumulated in the following cycle
            cmd.mem_rd  = 1'b1;
            cmd.col_sel = col_cnt_ff;
            cmd.row_sel = row_cnt_ff;
            cmd.acc_en  = !first_tap;
            if (col_cnt_ff == TAP_NEXT) begin
               col_cnt_in = TAP_PREV;
               row_cnt_in = row_cnt_ff + 2'd1;
            end else begin
               col_cnt_in = col_cnt_ff + 2'd1;
            end
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.acc_en = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.mult_en = 1'b1;
            out_sel_in  = OUT_MEAN;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         col_cnt_ff <= TAP_PREV;
         row_cnt_ff <= TAP_PREV;
         out_sel_ff <= OUT_ZERO;
      end else begin
         state_ff   <= state_in;
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         out_sel_ff <= out_sel_in;
      end
   end

endmodule

// ----- rtl/fsbf_dpath.sv -----
// Datapath: config registers, item register, wraparound address generation,
// single-port pixel memory, accumulators, divide by nine, output register.
// Uses fsbf_pkg.
module fsbf_dpath
   import fsbf_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  req_type                   req_data,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   input  ctrl_cmd_type              cmd,
   output ctrl_sts_type              sts,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data
);

   localparam int CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW  = CW + RW;
   localparam int DEPTH = 1 << AW;
   localparam int WSB = ($clog2(MAX_WIDTH + 1)  > CFG_SIZE_BITS) ?
                        $clog2(MAX_WIDTH + 1)  : CFG_SIZE_BITS;
   localparam int HSB = ($clog2(MAX_HEIGHT + 1) > CFG_SIZE_BITS) ?
                        $clog2(MAX_HEIGHT + 1) : CFG_SIZE_BITS;
   localparam int EXT = SUM_BITS - CHANNEL_BITS;

   // Config registers
   logic [CFG_SIZE_BITS-1:0] frame_width_ff;
   logic [CFG_SIZE_BITS-1:0] frame_height_ff;
   logic                     supersample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CFG_SIZE_BITS'(512);
         frame_height_ff <= CFG_SIZE_BITS'(512);
         supersample_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            CSR_SUPERSAMPLE:  supersample_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Item register
   req_type item_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
   end

   // Frame size in use, clamped to 1..MAX
   logic [WSB-1:0] fw_ext, w_eff, col_ext, col_prev, col_next, col_pick;
   logic [HSB-1:0] fh_ext, h_eff, row_ext, row_prev, row_next, row_pick;

   always_comb begin
      fw_ext = WSB'(frame_width_ff);
      fh_ext = HSB'(frame_height_ff);
      if (frame_width_ff == '0) begin
         w_eff = WSB'(1);
      end else if (fw_ext > WSB'(MAX_WIDTH)) begin
         w_eff = WSB'(MAX_WIDTH);
      end else begin
         w_eff = fw_ext;
      end
      if (frame_height_ff == '0) begin
         h_eff = HSB'(1);
      end else if (fh_ext > HSB'(MAX_HEIGHT)) begin
         h_eff = HSB'(MAX_HEIGHT);
      end else begin
         h_eff = fh_ext;
      end
   end

   // Wrapped neighbor coordinates
   always_comb begin
      col_ext  = WSB'(item_ff.column);
      row_ext  = HSB'(item_ff.row_index);
      col_prev = (col_ext == '0) ? w_eff - WSB'(1) : col_ext - WSB'(1);
      col_next = (col_ext + WSB'(1) == w_eff) ? '0 : col_ext + WSB'(1);
      row_prev = (row_ext == '0) ? h_eff - HSB'(1) : row_ext - HSB'(1);
      row_next = (row_ext + HSB'(1) == h_eff) ? '0 : row_ext + HSB'(1);
      case (cmd.col_sel)
         TAP_PREV: col_pick = col_prev;
         TAP_NEXT: col_pick = col_next;
         default:  col_pick = col_ext;
      endcase
      case (cmd.row_sel)
         TAP_PREV: row_pick = row_prev;
         TAP_NEXT: row_pick = row_next;
         default:  row_pick = row_ext;
      endcase
   end

   logic [AW-1:0] mem_addr;
   assign mem_addr = {row_pick[RW-1:0], col_pick[CW-1:0]};

   // Status
   assign sts.is_read     = (item_ff.command == CMD_READ);
   assign sts.in_frame    = (col_ext < w_eff) && (row_ext < h_eff);
   assign sts.supersample = supersample_ff;
   assign sts.out_free    = !rsp_valid || rsp_ready;

   // Pixel memory, one port
   pixel_type pixel_mem [DEPTH];
   pixel_type rd_data_ff;
   pixel_type wr_data;

   assign wr_data = '{red: item_ff.red_in, green: item_ff.green_in, blue: item_ff.blue_in};

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         pixel_mem[mem_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_data_ff <= pixel_mem[mem_addr];
      end
   end

   // Biased accumulators: start at 9 * 2^(CHANNEL_BITS-1) so the sum stays positive
   logic [SUM_BITS-1:0] acc_r_ff, acc_g_ff, acc_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         acc_r_ff <= ACC_BIAS;
         acc_g_ff <= ACC_BIAS;
         acc_b_ff <= ACC_BIAS;
      end else if (cmd.acc_en) begin
         acc_r_ff <= acc_r_ff + {{EXT{rd_data_ff.red[CHANNEL_BITS-1]}},   rd_data_ff.red};
         acc_g_ff <= acc_g_ff + {{EXT{rd_data_ff.green[CHANNEL_BITS-1]}}, rd_data_ff.green};
         acc_b_ff <= acc_b_ff + {{EXT{rd_data_ff.blue[CHANNEL_BITS-1]}},  rd_data_ff.blue};
      end
   end

   // Divide by nine: multiply by the rounded-up reciprocal, exact for this sum width
   logic [PROD_BITS-1:0] prod_r_ff, prod_g_ff, prod_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.mult_en) begin
         prod_r_ff <= PROD_BITS'(acc_r_ff) * PROD_BITS'(RECIP_NINE);
         prod_g_ff <= PROD_BITS'(acc_g_ff) * PROD_BITS'(RECIP_NINE);
         prod_b_ff <= PROD_BITS'(acc_b_ff) * PROD_BITS'(RECIP_NINE);
      end
   end

   // Removing the bias of 2^(CHANNEL_BITS-1) is a flip of the top bit
   localparam logic [CHANNEL_BITS-1:0] SIGN_FLIP = CHANNEL_BITS'(1) << (CHANNEL_BITS - 1);

   pixel_type mean;
   assign mean.red   = prod_r_ff[DIV_SHIFT +: CHANNEL_BITS] ^ SIGN_FLIP;
   assign mean.green = prod_g_ff[DIV_SHIFT +: CHANNEL_BITS] ^ SIGN_FLIP;
   assign mean.blue  = prod_b_ff[DIV_SHIFT +: CHANNEL_BITS] ^ SIGN_FLIP;

   // Output register
   pixel_type out_pick;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;

   always_comb begin
      case (cmd.out_sel)
         OUT_RAW:  out_pick = rd_data_ff;
         OUT_MEAN: out_pick = mean;
         default:  out_pick = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= '{red_out: out_pick.red, green_out: out_pick.green,
                          blue_out: out_pick.blue};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/frame_store_box_filter_3x3.sv -----
// Top level of the RGB frame store with 3x3 wraparound box filter on reads.
// Instantiates fsbf_ctrl and fsbf_dpath; uses fsbf_pkg.
//
// Usage:
//   req_* carries one beat per item: a write stores one pixel at (column,
//   row_index) and returns nothing; a read returns one beat on rsp_*.
//   csr_* writes frame_width (index 0), frame_height (1), supersample_on (2);
//   csr_ready is always high, writes belong between items.
//   Items are handled one at a time; req_ready is high only when idle.
//   A write passes through the decode state only; a plain or out-of-frame
//   read through decode and done; a filtered read through decode, filter,
//   drain, scale and done. A filtered read makes nine single-port memory
//   reads, one per cycle, then one accumulate, one multiply-by-reciprocal
//   for the divide by nine. rsp_valid rises when the done state loads the
//   result. The response sits in an output register; if the
//   receiver stalls with a result waiting, the next item is still accepted
//   and processed, and its result waits until the register is taken.
//   Synchronous reset clears control and restores the default frame size;
//   pixel memory contents are undefined until written.
module frame_store_box_filter_3x3
   import fsbf_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   assign csr_ready = 1'b1;

   // Sequencer
   fsbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath and pixel memory
   fsbf_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for frame_store_box_filter_3x3: plain and 3x3 wrapped-mean reads.
// Keeps its own shadow frame and predicts every rsp beat; needs rtl/fsbf_pkg.sv and the top.
`timescale 1ns / 1ps

module testbench;
   import fsbf_pkg::*;

   localparam int FRAME_COLS     = DEF_MAX_WIDTH;
   localparam int FRAME_ROWS     = DEF_MAX_HEIGHT;
   localparam int STORE_SIZE     = FRAME_COLS * FRAME_ROWS;
   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 20;
   localparam int IDLE_PERCENT   = 37;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 120;

   // Index 3 maps to no register and must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   localparam chan_type CHAN_MAX = {1'b0, {(CHANNEL_BITS-1){1'b1}}};
   localparam chan_type CHAN_MIN = {1'b1, {(CHANNEL_BITS-1){1'b0}}};

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   // Shadow of the block: pixel memory, written flags, register copies
   pixel_type                 shadow_frame   [0:STORE_SIZE-1];
   bit                        shadow_written [0:STORE_SIZE-1];
   logic [CSR_DATA_BITS-1:0]  cfg_width       = 10'd512;
   logic [CSR_DATA_BITS-1:0]  cfg_height      = 10'd512;
   logic                      cfg_supersample = 1'b0;
   rsp_type                   pending_pixels [$];

   int errors      = 0;
   int items_sent  = 0;
   bit steady      = 1'b0;
   int hold_asks   = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int quiet_count = 0;

   frame_store_box_filter_3x3 DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------

   function automatic int unsigned used_size(input logic [CSR_DATA_BITS-1:0] raw,
                                             input int unsigned top);
      if (raw == 0) return 1;
      if (raw > top) return top;
      return raw;
   endfunction

   function automatic int unsigned addr_of(input int unsigned col, input int unsigned row);
      return row * FRAME_COLS + col;
   endfunction

   // Neighbor coordinate with wraparound at both ends
   function automatic int unsigned wrap_step(input int unsigned pos, input int unsigned size,
                                             input logic [1:0] tap);
      case (tap)
         TAP_PREV: return (pos == 0) ? size - 1 : pos - 1;
         TAP_NEXT: return (pos + 1 == size) ? 0 : pos + 1;
         default:  return pos;
      endcase
   endfunction

   // Divide by nine, rounded toward minus infinity
   function automatic chan_type floor_ninth(input longint total);
      longint q;
      q = total / 9;
      if (total % 9 != 0 && total < 0) q = q - 1;
      return chan_type'(q);
   endfunction

   // Apply one accepted beat to the shadow frame; reads queue their pixel
   function automatic void apply_frame_op(input req_type item);
      int unsigned w, h, col, row, i, j;
      longint sum_r, sum_g, sum_b;
      pixel_type p;
      rsp_type pixel_out;
      w   = used_size(cfg_width, FRAME_COLS);
      h   = used_size(cfg_height, FRAME_ROWS);
      col = item.column;
      row = item.row_index;
      if (item.command == CMD_WRITE) begin
         if (col < w && row < h) begin
            shadow_frame[addr_of(col, row)]   = '{item.red_in, item.green_in, item.blue_in};
            shadow_written[addr_of(col, row)] = 1'b1;
         end
         return;
      end
      if (!(col < w && row < h)) begin
         pixel_out = '0;
      end else if (!cfg_supersample) begin
         p = shadow_frame[addr_of(col, row)];
         pixel_out = '{p.red, p.green, p.blue};
      end else begin
         sum_r = 0;
         sum_g = 0;
         sum_b = 0;
         for (j = TAP_PREV; j <= TAP_NEXT; j++) begin
            for (i = TAP_PREV; i <= TAP_NEXT; i++) begin
               p = shadow_frame[addr_of(wrap_step(col, w, 2'(i)), wrap_step(row, h, 2'(j)))];
               sum_r += longint'(p.red);
               sum_g += longint'(p.green);
               sum_b += longint'(p.blue);
            end
         end
         pixel_out = '{floor_ninth(sum_r), floor_ninth(sum_g), floor_ninth(sum_b)};
      end
      pending_pixels.push_back(pixel_out);
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_BITS-1:0] index,
                                     input logic [CSR_DATA_BITS-1:0] value);
      case (index)
         CSR_FRAME_WIDTH:  cfg_width = value;
         CSR_FRAME_HEIGHT: cfg_height = value;
         CSR_SUPERSAMPLE:  cfg_supersample = value[0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Checking, receiver, watchdog
   // ---------------------------------------------------------------

   function automatic void check_chan(input string field, input chan_type want,
                                      input chan_type got);
      if (got !== want) begin
         errors++;
         $error("%s: expected %0d, actual %0d", field, want, got);
      end
   endfunction

   // Compare each rsp beat with the oldest predicted pixel
   always @(posedge clock) begin
      rsp_type want;
      if (rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            errors++;
            $error("rsp beat with no read outstanding");
         end else begin
            want = pending_pixels.pop_front();
            check_chan("red_out", want.red_out, rsp_data.red_out);
            check_chan("green_out", want.green_out, rsp_data.green_out);
            check_chan("blue_out", want.blue_out, rsp_data.blue_out);
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: too long without any beat on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_count = 0;
      else
         quiet_count = quiet_count + 1;
      if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers (all entered at a rising edge)
   // ---------------------------------------------------------------

   function automatic chan_type rand_chan();
      case ($urandom_range(0, 9))
         0:       return CHAN_MAX;
         1:       return CHAN_MIN;
         2:       return '0;
         3:       return '1;
         default: return chan_type'($urandom);
      endcase
   endfunction

   // Coordinate inside the frame, biased toward both borders
   function automatic int unsigned pick_inside(input int unsigned limit);
      int unsigned near;
      near = $urandom_range(0, 2);
      if (near >= limit) near = limit - 1;
      case ($urandom_range(0, 3))
         0:       return near;
         1:       return limit - 1 - near;
         default: return $urandom_range(0, limit - 1);
      endcase
   endfunction

   // Coordinate pair off the frame; returns 0 when the frame covers the store
   function automatic bit pick_stray(input int unsigned w, input int unsigned h,
                                     output int unsigned col, output int unsigned row);
      col = pick_inside(w);
      row = pick_inside(h);
      if (w < FRAME_COLS && (h == FRAME_ROWS || $urandom_range(0, 1) == 1)) begin
         col = $urandom_range(w, FRAME_COLS - 1);
         return 1'b1;
      end
      if (h < FRAME_ROWS) begin
         row = $urandom_range(h, FRAME_ROWS - 1);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic req_type make_req(input logic command, input int unsigned col,
                                        input int unsigned row, input chan_type r,
                                        input chan_type g, input chan_type b);
      req_type item;
      item.command   = command;
      item.column    = COORD_BITS'(col);
      item.row_index = COORD_BITS'(row);
      item.red_in    = r;
      item.green_in  = g;
      item.blue_in   = b;
      return item;
   endfunction

   // Offer one req beat; valid stays up after acceptance until the next call
   // either loads a new beat or idles in that same step
   task automatic send_beat(input req_type item);
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_frame_op(item);
      items_sent++;
   endtask

   task automatic write_pixel(input int unsigned col, input int unsigned row,
                              input chan_type r, input chan_type g, input chan_type b);
      send_beat(make_req(CMD_WRITE, col, row, r, g, b));
   endtask

   task automatic read_pixel(input int unsigned col, input int unsigned row);
      send_beat(make_req(CMD_READ, col, row, rand_chan(), rand_chan(), rand_chan()));
   endtask

   // Read an in-frame pixel, first writing whatever it would touch unwritten
   task automatic fetch(input int unsigned col, input int unsigned row);
      int unsigned w, h, i, j, lo, hi, c, r;
      w  = used_size(cfg_width, FRAME_COLS);
      h  = used_size(cfg_height, FRAME_ROWS);
      lo = cfg_supersample ? TAP_PREV : TAP_CENTER;
      hi = cfg_supersample ? TAP_NEXT : TAP_CENTER;
      for (j = lo; j <= hi; j++) begin
         for (i = lo; i <= hi; i++) begin
            c = wrap_step(col, w, 2'(i));
            r = wrap_step(row, h, 2'(j));
            if (!shadow_written[addr_of(c, r)])
               write_pixel(c, r, rand_chan(), rand_chan(), rand_chan());
         end
      end
      read_pixel(col, row);
   endtask

   // Drop req valid, wait for every result, then let a last write finish
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One csr beat; valid is dropped again after it
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_BITS-1:0] width,
                            input logic [CSR_DATA_BITS-1:0] height,
                            input logic [CSR_DATA_BITS-1:0] supersample);
      drain();
      write_reg(CSR_FRAME_WIDTH, width);
      write_reg(CSR_FRAME_HEIGHT, height);
      write_reg(CSR_SUPERSAMPLE, supersample);
   endtask

   // Random mix of in-frame and off-frame reads and writes
   task automatic run_mixed(input int count);
      int unsigned w, h, col, row, pick, stop;
      bit stray;
      stop = items_sent + count;
      while (items_sent < stop) begin
         w    = used_size(cfg_width, FRAME_COLS);
         h    = used_size(cfg_height, FRAME_ROWS);
         pick = $urandom_range(0, 19);
         if (pick < 7) begin
            fetch(pick_inside(w), pick_inside(h));
         end else if (pick < 14) begin
            write_pixel(pick_inside(w), pick_inside(h), rand_chan(), rand_chan(), rand_chan());
         end else if (pick < 17) begin
            stray = pick_stray(w, h, col, row);
            write_pixel(col, row, rand_chan(), rand_chan(), rand_chan());
         end else begin
            stray = pick_stray(w, h, col, row);
            if (stray) read_pixel(col, row);
            else fetch(col, row);
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Stored pixels come back unchanged, corners and channel extremes
   task automatic test_plain_readback();
      configure(10'd512, 10'd512, 10'd0);
      write_pixel(0, 0, CHAN_MAX, CHAN_MIN, '0);
      write_pixel(511, 511, CHAN_MIN, '1, CHAN_MAX);
      write_pixel(511, 0, rand_chan(), rand_chan(), rand_chan());
      write_pixel(0, 511, rand_chan(), rand_chan(), rand_chan());
      read_pixel(0, 0);
      read_pixel(511, 511);
      read_pixel(511, 0);
      read_pixel(0, 511);
      write_pixel(0, 0, '1, CHAN_MAX, CHAN_MIN);
      read_pixel(0, 0);
   endtask

   // Wrapped mean at the corners, with exact extremes and floor on negatives
   task automatic test_wraparound_mean();
      int unsigned i, j;
      configure(10'd512, 10'd512, 10'd1);
      for (j = TAP_PREV; j <= TAP_NEXT; j++)
         for (i = TAP_PREV; i <= TAP_NEXT; i++)
            write_pixel(wrap_step(0, FRAME_COLS, 2'(i)), wrap_step(0, FRAME_ROWS, 2'(j)),
                        CHAN_MAX, CHAN_MIN, '0);
      read_pixel(0, 0);
      write_pixel(1, 1, CHAN_MIN, CHAN_MAX, '1);
      read_pixel(0, 0);
      fetch(511, 511);
   endtask

   // Size clamping, off-frame writes and reads, the unused register index
   task automatic test_frame_limits();
      configure(10'd0, 10'd0, 10'd1);
      write_pixel(0, 0, CHAN_MIN, CHAN_MAX, '1);
      read_pixel(0, 0);
      write_pixel(3, 0, rand_chan(), rand_chan(), rand_chan());
      write_pixel(0, 9, rand_chan(), rand_chan(), rand_chan());
      read_pixel(0, 0);
      read_pixel(8, 0);
      read_pixel(511, 511);
      configure(10'd1023, 10'd1, 10'd0);
      fetch(511, 0);
      read_pixel(0, 1);
      read_pixel(511, 511);
      configure(10'd600, 10'd2, 10'd1);
      fetch(0, 1);
      drain();
      write_reg(CSR_UNUSED, '1);
      write_reg(CSR_SUPERSAMPLE, 10'h3FE);
      fetch(300, 1);
   endtask

   // Phases over many frame sizes, both read modes
   task automatic test_random_frames();
      int unsigned phase;
      logic [CSR_DATA_BITS-1:0] w_raw, h_raw;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 6)
            0: begin w_raw = 10'd1023; h_raw = 10'd512; end
            1: begin w_raw = 10'd0;    h_raw = 10'd1; end
            2: begin
               w_raw = CSR_DATA_BITS'($urandom_range(1, 8));
               h_raw = CSR_DATA_BITS'($urandom_range(1, 8));
            end
            3: begin
               w_raw = CSR_DATA_BITS'($urandom_range(1, 40));
               h_raw = CSR_DATA_BITS'($urandom_range(1, 40));
            end
            4: begin
               w_raw = CSR_DATA_BITS'($urandom_range(0, 1023));
               h_raw = CSR_DATA_BITS'($urandom_range(0, 1023));
            end
            default: begin w_raw = 10'd3; h_raw = CSR_DATA_BITS'($urandom_range(1, 3)); end
         endcase
         configure(w_raw, h_raw, CSR_DATA_BITS'(((phase / 6) + phase) % 2));
         run_mixed(PHASE_ITEMS);
      end
   endtask

   // Receiver holds off while beats keep coming, so the block backs up
   task automatic test_output_backpressure();
      configure(10'd4, 10'd3, 10'd0);
      hold_asks <= hold_asks + 1;
      run_mixed(40);
      configure(10'd5, 10'd5, 10'd1);
      hold_asks <= hold_asks + 1;
      run_mixed(40);
   endtask

   // Long stretch with neither side idling
   task automatic test_steady_stream();
      configure(10'd7, 10'd5, 10'd1);
      steady = 1'b1;
      run_mixed(300);
      steady = 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_plain_readback();
      test_wraparound_mean();
      test_frame_limits();
      test_random_frames();
      test_output_backpressure();
      test_steady_stream();
      drain();
      if (errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/fsbf_pkg.sv
rtl/fsbf_ctrl.sv
rtl/fsbf_dpath.sv
rtl/frame_store_box_filter_3x3.sv
verif/testbench.sv
